/* rtl/core/bmf_pkg.sv */
// ----------------------------------------------------------------------------
// bmf_pkg: shared types and constants of the 3x3 box mean filter
// Holds the job and result records and the reciprocal table for the divider.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int COMP_W      = 16;
  localparam int POS_W       = 10;
  localparam int CFG_W       = 11;
  localparam int CNT_W       = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = 25;

  // Bit positions of the result kinds in a job mask, in emission order.
  localparam int RES_PREV_LEFT = 0;  // row r-1, column c-1
  localparam int RES_PREV_END  = 1;  // row r-1, column c at the row end
  localparam int RES_LAST_LEFT = 2;  // last row, column c-1
  localparam int RES_LAST_END  = 3;  // last row, column c at the row end

  // Classification of one accepted pixel, handed from front to back.
  typedef struct packed {
    logic [3:0]       mask;
    logic             r_ge1;
    logic             r_ge2;
    logic             c_ge1;
    logic             c_ge2;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } job_ctl_t;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic              last_of_run;
    logic              frame_done;
  } res_t;

  // Scaled reciprocal floor(2^24 / cnt) for the window sizes that occur.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd2:    m = 25'd8388608;
      4'd3:    m = 25'd5592405;
      4'd4:    m = 25'd4194304;
      4'd6:    m = 25'd2796202;
      4'd9:    m = 25'd1864135;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/bmf_fifo.sv */
// ----------------------------------------------------------------------------
// bmf_fifo: small first-in first-out queue
// Register-based queue with a fill count; the head entry is always visible.
// ----------------------------------------------------------------------------
module bmf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = store_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

endmodule

/* rtl/core/bmf_front.sv */
// ----------------------------------------------------------------------------
// bmf_front: pixel intake, line stores and window of the box mean filter
// Tracks the raster position, keeps two previous rows in one line memory,
// assembles the 3x3 column window and classifies the results each pixel owes.
// ----------------------------------------------------------------------------
module bmf_front #(
  parameter int MAX_SIDE       = 1024,
  parameter int COMPONENT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [bmf_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                          in_take,
  input  logic [bmf_pkg::COMP_W-1:0]    in_red,
  input  logic [bmf_pkg::COMP_W-1:0]    in_green,
  input  logic [bmf_pkg::COMP_W-1:0]    in_blue,
  output logic                          s1_busy,
  output logic                          job_push,
  output bmf_pkg::job_ctl_t             job_ctl,
  output logic [27*COMPONENT_BITS-1:0]  job_grid
);
  import bmf_pkg::*;

  localparam int ADDR_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int PIX_W    = 3 * COMPONENT_BITS;
  localparam int SIDE_RST = (MAX_SIDE < 64) ? MAX_SIDE : 64;
  localparam logic [ADDR_W-1:0] NM1_RST = ADDR_W'(SIDE_RST - 1);
  localparam logic [ADDR_W-1:0] NM1_MAX = ADDR_W'(MAX_SIDE - 1);

  logic [ADDR_W-1:0]  r_r, r_nxt;
  logic [ADDR_W-1:0]  c_r, c_nxt;
  logic [ADDR_W-1:0]  nm1_r, nm1_nxt;
  logic [ADDR_W-1:0]  nm1_sat;
  logic [PIX_W-1:0]   px;
  job_ctl_t           ctl;

  logic [2*PIX_W-1:0] line_mem [MAX_SIDE];
  logic [2*PIX_W-1:0] rd_r;
  logic               s1_valid_r;
  logic [ADDR_W-1:0]  s1_c_r;
  logic [PIX_W-1:0]   s1_px_r;
  job_ctl_t           s1_ctl_r;
  logic               s1_byp_r;
  logic [2*PIX_W-1:0] s1_bypd_r;
  logic [2*PIX_W-1:0] eff_rd;
  logic [2*PIX_W-1:0] wr_data;
  logic [PIX_W-1:0]   older;
  logic [PIX_W-1:0]   newer;
  logic [3*PIX_W-1:0] col2;
  logic [3*PIX_W-1:0] win1_r;
  logic [3*PIX_W-1:0] win0_r;

  // Side length saturated to 1..MAX_SIDE, kept as side minus one.
  always_comb begin
    if (cfg_wr_data == '0) begin
      nm1_sat = '0;
    end else if (int'(cfg_wr_data) > MAX_SIDE) begin
      nm1_sat = NM1_MAX;
    end else begin
      nm1_sat = ADDR_W'(cfg_wr_data - 1'b1);
    end
  end

  // Raster position; a size write restarts the frame.
  always_comb begin
    r_nxt   = r_r;
    c_nxt   = c_r;
    nm1_nxt = nm1_r;
    if (cfg_wr_en) begin
      nm1_nxt = nm1_sat;
      r_nxt   = '0;
      c_nxt   = '0;
    end else if (in_take) begin
      if (c_r == nm1_r) begin
        c_nxt = '0;
        r_nxt = (r_r == nm1_r) ? '0 : r_r + 1'b1;
      end else begin
        c_nxt = c_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r   <= '0;
      c_r   <= '0;
      nm1_r <= NM1_RST;
    end else begin
      r_r   <= r_nxt;
      c_r   <= c_nxt;
      nm1_r <= nm1_nxt;
    end
  end

  // Classify the results owed by the pixel at the current position.
  always_comb begin
    ctl.r_ge1 = (r_r != '0);
    ctl.r_ge2 = (r_r > ADDR_W'(1));
    ctl.c_ge1 = (c_r != '0);
    ctl.c_ge2 = (c_r > ADDR_W'(1));
    ctl.mask[RES_PREV_LEFT] = ctl.r_ge1 && ctl.c_ge1;
    ctl.mask[RES_PREV_END]  = ctl.r_ge1 && (c_r == nm1_r);
    ctl.mask[RES_LAST_LEFT] = (r_r == nm1_r) && ctl.c_ge1;
    ctl.mask[RES_LAST_END]  = (r_r == nm1_r) && (c_r == nm1_r);
    ctl.row = POS_W'(r_r);
    ctl.col = POS_W'(c_r);
  end

  assign px = {in_blue[COMPONENT_BITS-1:0], in_green[COMPONENT_BITS-1:0],
               in_red[COMPONENT_BITS-1:0]};

  // Stage one registers: pixel, column and classification.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_c_r    <= c_r;
      s1_px_r   <= px;
      s1_ctl_r  <= ctl;
      s1_byp_r  <= s1_valid_r && (s1_c_r == c_r);
      s1_bypd_r <= wr_data;
    end
  end

  // Line memory: upper half holds row r-2, lower half row r-1.
  // A read of the column being written in the same cycle takes the new data.
  assign eff_rd  = s1_byp_r ? s1_bypd_r : rd_r;
  assign older   = eff_rd[2*PIX_W-1:PIX_W];
  assign newer   = eff_rd[PIX_W-1:0];
  assign wr_data = {newer, s1_px_r};

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_mem[s1_c_r] <= wr_data;
    end
    if (in_take) begin
      rd_r <= line_mem[c_r];
    end
  end

  // Column window: current column, then the two before it.
  assign col2 = {s1_px_r, newer, older};

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      win0_r <= win1_r;
      win1_r <= col2;
    end
  end

  assign job_grid = {col2, win1_r, win0_r};
  assign job_ctl  = s1_ctl_r;
  assign job_push = s1_valid_r && (s1_ctl_r.mask != 4'b0000);
  assign s1_busy  = s1_valid_r;

endmodule

/* rtl/core/bmf_back.sv */
// ----------------------------------------------------------------------------
// bmf_back: result generator of the box mean filter
// Walks the results owed by each job, sums the clipped window and divides
// by its pixel count through a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module bmf_back #(
  parameter int COMPONENT_BITS = 16,
  parameter int RES_DEPTH      = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             job_empty,
  input  bmf_pkg::job_ctl_t                job_ctl,
  input  logic [27*COMPONENT_BITS-1:0]     job_grid,
  output logic                             job_pop,
  input  logic [$clog2(RES_DEPTH+1)-1:0]   oq_count,
  output logic                             res_push,
  output bmf_pkg::res_t                    res
);
  import bmf_pkg::*;

  localparam int PIX_W  = 3 * COMPONENT_BITS;
  localparam int SUM_W  = COMPONENT_BITS + 4;
  localparam int PROD_W = SUM_W + RECIP_W;
  localparam int OQ_W   = $clog2(RES_DEPTH + 1) + 2;

  logic [3:0]       rem_r;
  logic             rem_valid_r;
  logic [3:0]       cur_mask;
  logic [3:0]       sel;
  logic [3:0]       next_mask;
  logic             issue;
  logic             kc2;
  logic             mc2;
  logic [2:0]       col_en;
  logic [2:0]       row_en;
  logic [1:0]       ncols;
  logic [1:0]       nrows;
  logic [SUM_W-1:0] sum_c [3];

  logic             va_r;
  logic [SUM_W-1:0] a_sum_r [3];
  logic [CNT_W-1:0] a_cnt_r;
  logic [POS_W-1:0] a_row_r;
  logic [POS_W-1:0] a_col_r;
  logic             a_last_r;
  logic             a_fd_r;

  logic              vb_r;
  logic [PROD_W-1:0] b_prod_r [3];
  logic [SUM_W-1:0]  b_sum_r [3];
  logic [CNT_W-1:0]  b_cnt_r;
  logic [POS_W-1:0]  b_row_r;
  logic [POS_W-1:0]  b_col_r;
  logic              b_last_r;
  logic              b_fd_r;

  logic [SUM_W-1:0] mean [3];

  // Pick the next result kind of the head job, lowest mask bit first.
  assign cur_mask  = rem_valid_r ? rem_r : job_ctl.mask;
  assign sel       = cur_mask & (~cur_mask + 4'd1);
  assign next_mask = cur_mask & ~sel;
  assign issue     = !job_empty &&
                     (OQ_W'(oq_count) + OQ_W'(va_r) + OQ_W'(vb_r) < OQ_W'(RES_DEPTH));
  assign job_pop   = issue && (next_mask == 4'b0000);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_valid_r <= 1'b0;
      rem_r       <= 4'b0000;
    end else if (issue) begin
      rem_valid_r <= (next_mask != 4'b0000);
      rem_r       <= next_mask;
    end
  end

  // Clipped window of the selected result and its masked sums.
  always_comb begin
    kc2 = sel[RES_PREV_END] | sel[RES_LAST_END];
    mc2 = sel[RES_LAST_LEFT] | sel[RES_LAST_END];
    col_en = kc2 ? {1'b1, job_ctl.c_ge1, 1'b0} : {1'b1, 1'b1, job_ctl.c_ge2};
    row_en = mc2 ? {1'b1, job_ctl.r_ge1, 1'b0} : {1'b1, 1'b1, job_ctl.r_ge2};
    ncols = 2'(col_en[0]) + 2'(col_en[1]) + 2'(col_en[2]);
    nrows = 2'(row_en[0]) + 2'(row_en[1]) + 2'(row_en[2]);
    for (int q = 0; q < 3; q++) begin
      sum_c[q] = '0;
      for (int k = 0; k < 3; k++) begin
        for (int m = 0; m < 3; m++) begin
          if (col_en[k] && row_en[m]) begin
            sum_c[q] = sum_c[q] + SUM_W'(
              job_grid[(k*3+m)*PIX_W + q*COMPONENT_BITS +: COMPONENT_BITS]);
          end
        end
      end
    end
  end

  // Stage A: window sums and result tags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= issue;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int q = 0; q < 3; q++) begin
        a_sum_r[q] <= sum_c[q];
      end
      a_cnt_r  <= CNT_W'(ncols) * CNT_W'(nrows);
      a_row_r  <= mc2 ? job_ctl.row : job_ctl.row - 1'b1;
      a_col_r  <= kc2 ? job_ctl.col : job_ctl.col - 1'b1;
      a_last_r <= (next_mask == 4'b0000);
      a_fd_r   <= sel[RES_LAST_END];
    end
  end

  // Stage B: multiply by the scaled reciprocal of the count.
  always_ff @(posedge clk) begin
    if (va_r) begin
      for (int q = 0; q < 3; q++) begin
        b_prod_r[q] <= PROD_W'(a_sum_r[q]) * PROD_W'(recip(a_cnt_r));
        b_sum_r[q]  <= a_sum_r[q];
      end
      b_cnt_r  <= a_cnt_r;
      b_row_r  <= a_row_r;
      b_col_r  <= a_col_r;
      b_last_r <= a_last_r;
      b_fd_r   <= a_fd_r;
    end
  end

  // Stage C: the estimate is exact or one low; one compare fixes it.
  always_comb begin
    logic [SUM_W-1:0] q0;
    logic [SUM_W-1:0] rem;
    for (int q = 0; q < 3; q++) begin
      q0  = b_prod_r[q][RECIP_SHIFT +: SUM_W];
      rem = b_sum_r[q] - SUM_W'(q0 * b_cnt_r);
      mean[q] = (rem >= SUM_W'(b_cnt_r)) ? q0 + 1'b1 : q0;
    end
  end

  assign res_push        = vb_r;
  assign res.red         = COMP_W'(mean[0]);
  assign res.green       = COMP_W'(mean[1]);
  assign res.blue        = COMP_W'(mean[2]);
  assign res.row         = b_row_r;
  assign res.col         = b_col_r;
  assign res.last_of_run = b_last_r;
  assign res.frame_done  = b_fd_r;

  // A job leaves the queue only with its final result.
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> issue && (next_mask == 4'b0000))
    else $error("job popped before its last result");

  // Each issue picks exactly one result kind.
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> $onehot(sel))
    else $error("result selection not one-hot");

  // A partly served job always has results left.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rem_valid_r |-> (rem_r != 4'b0000))
    else $error("partly served job with empty mask");

endmodule

/* rtl/core/box_mean_filter_3x3_clipped.sv */
// ----------------------------------------------------------------------------
// box_mean_filter_3x3_clipped: streaming 3x3 box mean over a square RGB image
// Front stage with line memory and window, job queue, divider back end and
// an output queue.
// ----------------------------------------------------------------------------
// The block takes one raster pixel per clock while its job queue has room and
// returns, per pixel, zero to four mean results tagged with row and column.
// A pixel is registered in the front (line memory read, window assembly)
// before its job enters the job queue; the back end issues one result per
// clock while a job waits and the output queue has room, and writes it to the
// output queue through its stages A and B. The first row yields no results,
// other rows n results per n pixels and the last row 2n, so input stalls
// there once the queues fill. The size register restarts the frame when
// written; the line memories need no clear.
module box_mean_filter_3x3_clipped #(
  parameter int MAX_SIDE       = 1024,
  parameter int COMPONENT_BITS = 16,
  parameter int JOB_DEPTH      = 4,
  parameter int RES_DEPTH      = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [bmf_pkg::CFG_W-1:0]   cfg_wr_data,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [bmf_pkg::COMP_W-1:0]  in_red,
  input  logic [bmf_pkg::COMP_W-1:0]  in_green,
  input  logic [bmf_pkg::COMP_W-1:0]  in_blue,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [bmf_pkg::COMP_W-1:0]  out_red,
  output logic [bmf_pkg::COMP_W-1:0]  out_green,
  output logic [bmf_pkg::COMP_W-1:0]  out_blue,
  output logic [bmf_pkg::POS_W-1:0]   out_row,
  output logic [bmf_pkg::POS_W-1:0]   out_col,
  output logic                        out_last_of_run,
  output logic                        out_frame_done
);
  import bmf_pkg::*;

  localparam int GRID_W = 27 * COMPONENT_BITS;
  localparam int CTL_W  = $bits(job_ctl_t);
  localparam int JOB_W  = CTL_W + GRID_W;
  localparam int JQ_W   = $clog2(JOB_DEPTH + 1);
  localparam int OQ_W   = $clog2(RES_DEPTH + 1);

  logic              in_take;
  logic              s1_busy;
  logic              job_push;
  job_ctl_t          f_ctl;
  logic [GRID_W-1:0] f_grid;
  logic [JOB_W-1:0]  jq_dout;
  logic              jq_empty;
  logic [JQ_W-1:0]   jq_count;
  job_ctl_t          b_ctl;
  logic              job_pop;
  logic              res_push;
  res_t              res_in;
  res_t              res_out;
  logic [OQ_W-1:0]   oq_count;
  logic              oq_empty;

  // A pixel transfer needs a free job slot, counting the one in the front.
  assign in_full = (JQ_W+1)'(jq_count) + (JQ_W+1)'(s1_busy) >= (JQ_W+1)'(JOB_DEPTH);
  assign in_take = in_push && !in_full;

  bmf_front #(
    .MAX_SIDE       (MAX_SIDE),
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_take     (in_take),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .s1_busy     (s1_busy),
    .job_push    (job_push),
    .job_ctl     (f_ctl),
    .job_grid    (f_grid)
  );

  // Job queue between front and back.
  bmf_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   ({f_ctl, f_grid}),
    .pop   (job_pop),
    .dout  (jq_dout),
    .empty (jq_empty),
    .count (jq_count)
  );

  assign b_ctl = jq_dout[JOB_W-1:GRID_W];

  bmf_back #(
    .COMPONENT_BITS (COMPONENT_BITS),
    .RES_DEPTH      (RES_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (jq_empty),
    .job_ctl   (b_ctl),
    .job_grid  (jq_dout[GRID_W-1:0]),
    .job_pop   (job_pop),
    .oq_count  (oq_count),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Output queue; the back end never overfills it.
  bmf_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .pop   (out_pop && !oq_empty),
    .dout  (res_out),
    .empty (oq_empty),
    .count (oq_count)
  );

  assign out_empty       = oq_empty;
  assign out_red         = res_out.red;
  assign out_green       = res_out.green;
  assign out_blue        = res_out.blue;
  assign out_row         = res_out.row;
  assign out_col         = res_out.col;
  assign out_last_of_run = res_out.last_of_run;
  assign out_frame_done  = res_out.frame_done;

endmodule
